>>> hdl/aspb_pkg.sv
// Shared constants and controller/datapath interface types for the playback buffer.
package aspb_pkg;

   localparam int BLOCK_FRAMES_DEF = 256;
   localparam int RING_BLOCKS_DEF  = 16;

   localparam int FUNC_W     = 2;
   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 24;
   localparam int WORD_W     = 32;
   localparam int WRITABLE_W = 9;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
      logic tick;
      logic setup;
      logic copy;
      logic next_blk;
      logic resp_load;
   } cmd_type;

   typedef struct packed {
      logic is_tick;
      logic start_fill;
      logic tick_fill;
      logic fill_empty;
      logic copy_done;
   } stat_type;

endpackage

>>> hdl/aspb_ctrl.sv
// Controller state machine sequencing item execution, block fills and response.
module aspb_ctrl
   import aspb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_EXEC  = 6'b000010,
      ST_TICK  = 6'b000100,
      ST_SETUP = 6'b001000,
      ST_COPY  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.is_tick) begin
               state_in = ST_TICK;
            end else if (stat.start_fill) begin
               second_in = 1'b1;
               state_in  = ST_SETUP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_TICK: begin
            cmd.tick = 1'b1;
            state_in = stat.tick_fill ? ST_SETUP : ST_RESP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (!stat.fill_empty) begin
               state_in = ST_COPY;
            end else if (second_ff) begin
               second_in    = 1'b0;
               cmd.next_blk = 1'b1;
               state_in     = ST_SETUP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            if (stat.copy_done) begin
               if (second_ff) begin
                  second_in    = 1'b0;
                  cmd.next_blk = 1'b1;
                  state_in     = ST_SETUP;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> hdl/aspb_dp.sv
// Datapath: ring and output block memories, stream state and response register.
module aspb_dp
   import aspb_pkg::*;
#(
   parameter int BLOCK_FRAMES = BLOCK_FRAMES_DEF,
   parameter int RING_BLOCKS  = RING_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [0:0]            csr_data,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int POS_W      = (BLOCK_FRAMES > 1) ? $clog2(BLOCK_FRAMES) : 1;
   localparam int CNT_W      = $clog2(BLOCK_FRAMES + 1);
   localparam int RB_W       = (RING_BLOCKS > 1) ? $clog2(RING_BLOCKS) : 1;
   localparam int RDY_W      = $clog2(RING_BLOCKS + 1);
   localparam int RING_DEPTH = 1 << (RB_W + POS_W);
   localparam int OUT_DEPTH  = 2 << POS_W;

   localparam logic [CNT_W-1:0]   BF_CNT   = CNT_W'(BLOCK_FRAMES);
   localparam logic [COUNT_W-1:0] BF_WIDE  = COUNT_W'(BLOCK_FRAMES);
   localparam logic [POS_W-1:0]   LAST_POS = POS_W'(BLOCK_FRAMES - 1);
   localparam logic [RB_W-1:0]    RB_LAST  = RB_W'(RING_BLOCKS - 1);
   localparam logic [RDY_W-1:0]   RB_FULL  = RDY_W'(RING_BLOCKS);

   logic [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
   logic [SAMPLE_W-1:0] out_mem  [OUT_DEPTH];

   logic [FUNC_W-1:0]   func_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [COUNT_W-1:0]  total_ff;

   logic [RB_W-1:0]     rp_ff, rp_in, wp_ff, wp_in;
   logic [RDY_W-1:0]    ready_ff, ready_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [COUNT_W-1:0]  expected_ff, expected_in, received_ff, received_in;
   logic                open_ff, open_in, playing_ff, playing_in;
   logic [CNT_W-1:0]    out_cnt_ff [2];
   logic [CNT_W-1:0]    out_cnt_in [2];
   logic [1:0]          final_ff, final_in;
   logic                active_ff, active_in;
   logic [POS_W-1:0]    tx_pos_ff, tx_pos_in;
   logic                fill_blk_ff, fill_blk_in;
   logic                wr_valid_ff, wr_valid_in;
   logic                mono_ff;

   logic [RB_W-1:0]     copy_src_ff, copy_src_in;
   logic [CNT_W-1:0]    copy_cnt_ff, copy_cnt_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [POS_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [SAMPLE_W-1:0] ring_rdata_ff, ob_rdata_ff;
   logic                ob_in_ff;
   logic                status_ff, status_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [CNT_W-1:0]    ring_cnt_ff [RING_BLOCKS];
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic [COUNT_W-1:0]  remaining;
   logic [CNT_W-1:0]    target, needed, fill_inc, setup_cnt;
   logic                can_write, write_ok, commit, start_ok, wrap, fill_avail;
   logic [SAMPLE_W-1:0] tx_sample;
   logic [RB_W-1:0]     wp_next, rp_next;

   always_comb begin
      remaining  = expected_ff - received_ff;
      target     = (remaining < BF_WIDE) ? CNT_W'(remaining) : BF_CNT;
      can_write  = open_ff && (ready_ff < RB_FULL) && (received_ff < expected_ff);
      needed     = (can_write && (target > fill_ff)) ? (target - fill_ff) : '0;
      write_ok   = (needed != '0);
      fill_inc   = fill_ff + 1'b1;
      commit     = (fill_inc >= target);
      start_ok   = !open_ff && (total_ff != '0);
      wrap       = (tx_pos_ff == LAST_POS);
      fill_avail = open_ff && (ready_ff != '0);
      wp_next    = (wp_ff == RB_LAST) ? '0 : wp_ff + 1'b1;
      rp_next    = (rp_ff == RB_LAST) ? '0 : rp_ff + 1'b1;
      setup_cnt  = fill_avail ? ring_cnt_ff[rp_ff] : '0;
      tx_sample  = ob_in_ff ? ob_rdata_ff : '0;
   end

   always_comb begin
      stat.is_tick    = (func_ff == FUNC_TICK);
      stat.start_fill = (func_ff == FUNC_WRITE) && write_ok && commit && !playing_ff;
      stat.tick_fill  = wrap && playing_ff && !final_ff[active_ff] && !final_ff[!active_ff];
      stat.fill_empty = (setup_cnt == '0);
      stat.copy_done  = (rd_idx_ff == copy_cnt_ff) && !wr_valid_ff;
   end

   always_comb begin
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      ready_in    = ready_ff;
      fill_in     = fill_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      open_in     = open_ff;
      playing_in  = playing_ff;
      out_cnt_in  = out_cnt_ff;
      final_in    = final_ff;
      active_in   = active_ff;
      tx_pos_in   = tx_pos_ff;
      fill_blk_in = fill_blk_ff;
      wr_valid_in = wr_valid_ff;
      copy_src_in = copy_src_ff;
      copy_cnt_in = copy_cnt_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      status_in   = status_ff;
      word_in     = word_ff;

      if (cmd.exec) begin
         word_in   = '0;
         status_in = 1'b0;
         unique case (func_ff)
            FUNC_START: begin
               if (start_ok) begin
                  open_in     = 1'b1;
                  playing_in  = 1'b0;
                  rp_in       = '0;
                  wp_in       = '0;
                  ready_in    = '0;
                  fill_in     = '0;
                  expected_in = total_ff;
                  received_in = '0;
               end else begin
                  status_in = 1'b1;
               end
            end
            FUNC_WRITE: begin
               if (!write_ok) begin
                  status_in = 1'b1;
               end else if (commit) begin
                  wp_in       = wp_next;
                  ready_in    = ready_ff + 1'b1;
                  received_in = received_ff + COUNT_W'(target);
                  fill_in     = '0;
                  if (!playing_ff) begin
                     playing_in  = 1'b1;
                     active_in   = 1'b0;
                     tx_pos_in   = '0;
                     fill_blk_in = 1'b0;
                  end
               end else begin
                  fill_in = fill_inc;
               end
            end
            FUNC_TICK: begin
               status_in = 1'b0;
            end
            default: begin
               status_in = 1'b1;
            end
         endcase
      end

      if (cmd.tick) begin
         word_in = {tx_sample, (mono_ff ? {SAMPLE_W{1'b0}} : tx_sample)};
         if (wrap) begin
            tx_pos_in = '0;
            if (playing_ff) begin
               if (final_ff[active_ff]) begin
                  playing_in    = 1'b0;
                  open_in       = 1'b0;
                  out_cnt_in[0] = '0;
                  out_cnt_in[1] = '0;
                  active_in     = 1'b0;
               end else begin
                  active_in   = !active_ff;
                  fill_blk_in = active_ff;
               end
            end
         end else begin
            tx_pos_in = tx_pos_ff + 1'b1;
         end
      end

      if (cmd.setup) begin
         wr_valid_in = 1'b0;
         rd_idx_in   = '0;
         copy_cnt_in = setup_cnt;
         if (fill_avail) begin
            copy_src_in = rp_ff;
            rp_in       = rp_next;
            ready_in    = ready_ff - 1'b1;
         end
         out_cnt_in[fill_blk_ff] = setup_cnt;
         final_in[fill_blk_ff]   = (setup_cnt != '0) && (received_ff == expected_ff) &&
                                   (ready_in == '0);
      end

      if (cmd.copy) begin
         if (rd_idx_ff < copy_cnt_ff) begin
            rd_idx_in   = rd_idx_ff + 1'b1;
            wr_valid_in = 1'b1;
            wr_idx_in   = rd_idx_ff[POS_W-1:0];
         end else begin
            wr_valid_in = 1'b0;
         end
      end

      if (cmd.next_blk) begin
         fill_blk_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff       <= '0;
         wp_ff       <= '0;
         ready_ff    <= '0;
         fill_ff     <= '0;
         expected_ff <= '0;
         received_ff <= '0;
         open_ff     <= 1'b0;
         playing_ff  <= 1'b0;
         out_cnt_ff  <= '{default: '0};
         final_ff    <= '0;
         active_ff   <= 1'b0;
         tx_pos_ff   <= '0;
         fill_blk_ff <= 1'b0;
         wr_valid_ff <= 1'b0;
         mono_ff     <= 1'b0;
      end else begin
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         ready_ff    <= ready_in;
         fill_ff     <= fill_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
         open_ff     <= open_in;
         playing_ff  <= playing_in;
         out_cnt_ff  <= out_cnt_in;
         final_ff    <= final_in;
         active_ff   <= active_in;
         tx_pos_ff   <= tx_pos_in;
         fill_blk_ff <= fill_blk_in;
         wr_valid_ff <= wr_valid_in;
         if (csr_valid && csr_ready) begin
            mono_ff <= csr_data[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff   <= req_tuser;
         sample_ff <= req_tdata[SAMPLE_W-1:0];
         total_ff  <= req_tdata[SAMPLE_W +: COUNT_W];
      end
      copy_src_ff <= copy_src_in;
      copy_cnt_ff <= copy_cnt_in;
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      status_ff   <= status_in;
      word_ff     <= word_in;
      if (cmd.exec && (func_ff == FUNC_WRITE) && write_ok && commit) begin
         ring_cnt_ff[wp_ff] <= target;
      end
      if (cmd.resp_load) begin
         rsp_ff <= RSP_DATA_W'({WRITABLE_W'(needed), open_ff, word_ff, status_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && (func_ff == FUNC_WRITE) && write_ok) begin
         ring_mem[{wp_ff, fill_ff[POS_W-1:0]}] <= sample_ff;
      end
      if (cmd.copy && (rd_idx_ff < copy_cnt_ff)) begin
         ring_rdata_ff <= ring_mem[{copy_src_ff, rd_idx_ff[POS_W-1:0]}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.copy && wr_valid_ff) begin
         out_mem[{fill_blk_ff, wr_idx_ff}] <= ring_rdata_ff;
      end
      if (cmd.exec) begin
         ob_rdata_ff <= out_mem[{active_ff, tx_pos_ff}];
         ob_in_ff    <= (CNT_W'(tx_pos_ff) < out_cnt_ff[active_ff]);
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

>>> hdl/audio_stream_playback_buffer.sv
// Top level of the streaming audio playback buffer with ping-pong output blocks.
//
// Usage: each transfer on the req_ channel is one command: start a stream of
// total_count samples, write one sample, or tick (take one packed output word).
// Every command yields exactly one transfer on the rsp_ channel with status,
// tx_word, busy_res and writable. The csr_ channel writes mono_mode and is
// always ready; write it only while no command is in flight.
// Commands are handled one at a time: an accepted command steps through the execute
// state, then any tick and fill states, then the response state, which loads the
// response register and raises rsp_tvalid; the next command is accepted back in idle.
// A write that commits the first block of a stream fills both output blocks
// from the ring, and a tick that ends an output block refills it unless either block
// holds the stream's final data; each fill sets up the block, then walks the ring
// memory one sample per cycle for its count (up to BLOCK_FRAMES); a silent block only sets up.
// Reset clears all stream state, the mode register and the output block counts, so
// both blocks play silence; no clearing pass is needed. When rsp_tready is low the response
// register holds its transfer; one more command is accepted and executed, then holds
// its response until the register drains, and no further command is accepted.
module audio_stream_playback_buffer
   import aspb_pkg::*;
#(
   parameter int BLOCK_FRAMES = BLOCK_FRAMES_DEF,
   parameter int RING_BLOCKS  = RING_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample[15:0], total_count[39:16]
   input  logic [FUNC_W-1:0]     req_tuser,   // func[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status[0], tx_word[32:1], busy_res[33],
                                              // writable[42:34], zero[47:43]
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [0:0]            csr_data     // mono_mode[0]
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   aspb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   aspb_dp #(
      .BLOCK_FRAMES (BLOCK_FRAMES),
      .RING_BLOCKS  (RING_BLOCKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command accepted while another is in flight");

   a_idle_not_writable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[33] |-> rsp_tdata[42:34] == 9'd0)
      else $error("writable reported with no open stream");

   a_reject_no_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[32:1] == 32'd0)
      else $error("rejected command carries an output word");

endmodule
